// ===== rtl/sfb_pkg.sv =====
package sfb_pkg;

  localparam int unsigned COL_W       = 13;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [COL_W-1:0] MAX_COLUMNS = COL_W'(4096);
  localparam logic [PIX_W-1:0] DARK_LEVEL  = PIX_W'(10);

  // Blend numerator: base*(W-k) + over*k stays below 256*W <= 2^20.
  localparam int unsigned NUM_W      = PIX_W + COL_W;
  localparam int unsigned QUO_W      = PIX_W;
  localparam int unsigned QBITS      = 2;
  localparam int unsigned DIV_STAGES = QUO_W / QBITS;

  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NUM_CH-1:0] rgb_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef num_t [NUM_CH-1:0] num_vec_t;

  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_OVER,
    SEL_BLEND
  } sel_t;

  // After column classification.
  typedef struct packed {
    sel_t             sel;
    logic [COL_W-1:0] span;
    logic [COL_W-1:0] k;
    logic [COL_W-1:0] rk;
    rgb_t             base;
    rgb_t             over;
  } cls_t;

  // After the weight multiplies.
  typedef struct packed {
    sel_t             sel;
    logic [COL_W-1:0] span;
    rgb_t             base;
    rgb_t             over;
    num_vec_t         num;
  } prod_t;

  // One step of the restoring divider.
  typedef struct packed {
    sel_t             sel;
    logic [COL_W-1:0] span;
    rgb_t             base;
    rgb_t             over;
    num_vec_t         rem;
    rgb_t             quo;
  } div_t;

endpackage

// ===== rtl/sfb_prep.sv =====
module sfb_prep (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [sfb_pkg::COL_W-1:0] column,
  input  sfb_pkg::rgb_t             base,
  input  sfb_pkg::rgb_t             over,
  input  logic [sfb_pkg::COL_W-1:0] ov_start,
  input  logic [sfb_pkg::COL_W-1:0] img_width,
  input  logic                      dn_ready,
  output logic                      dn_valid,
  output sfb_pkg::prod_t            dn_data
);
  import sfb_pkg::*;

  cls_t             cls_nxt;
  cls_t             cls_r;
  logic             cls_vld_r;
  prod_t            prod_nxt;
  prod_t            prod_r;
  logic             prod_vld_r;
  logic             cls_rdy;
  logic             prod_rdy;
  logic [COL_W-1:0] s_eff;
  logic             dark;

  assign prod_rdy = !prod_vld_r || dn_ready;
  assign cls_rdy  = !cls_vld_r || prod_rdy;
  assign up_ready = cls_rdy;
  assign dn_valid = prod_vld_r;
  assign dn_data  = prod_r;

  // Classify the column against the clamped overlap window.
  always_comb begin
    s_eff = (ov_start > img_width) ? img_width : ov_start;
    dark  = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (over[c] > DARK_LEVEL) begin
        dark = 1'b0;
      end
    end
    cls_nxt.base = base;
    cls_nxt.over = over;
    cls_nxt.span = img_width - s_eff;
    cls_nxt.k    = column - s_eff;
    cls_nxt.rk   = img_width - column;
    priority if (column < s_eff) begin
      cls_nxt.sel = SEL_BASE;
    end else if (column >= img_width) begin
      cls_nxt.sel = SEL_OVER;
    end else if (dark) begin
      cls_nxt.sel = SEL_BASE;
    end else begin
      cls_nxt.sel = SEL_BLEND;
    end
  end

  always_comb begin
    prod_nxt.sel  = cls_r.sel;
    prod_nxt.span = cls_r.span;
    prod_nxt.base = cls_r.base;
    prod_nxt.over = cls_r.over;
    for (int c = 0; c < NUM_CH; c++) begin
      prod_nxt.num[c] = NUM_W'(cls_r.base[c]) * NUM_W'(cls_r.rk)
                      + NUM_W'(cls_r.over[c]) * NUM_W'(cls_r.k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      if (cls_rdy) begin
        cls_vld_r <= up_valid;
      end
      if (prod_rdy) begin
        prod_vld_r <= cls_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_rdy) begin
      cls_r <= cls_nxt;
    end
    if (prod_rdy) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/sfb_div.sv =====
module sfb_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  sfb_pkg::prod_t up_data,
  input  logic           dn_ready,
  output logic           dn_valid,
  output sfb_pkg::div_t  dn_data
);
  import sfb_pkg::*;

  div_t                  src_d   [DIV_STAGES];
  div_t                  stg_nxt [DIV_STAGES];
  div_t                  stg_r   [DIV_STAGES];
  logic [DIV_STAGES-1:0] src_vld;
  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES:0]   rdy;

  // A stage takes a new word when it is empty or its successor moves on.
  always_comb begin
    rdy[DIV_STAGES] = dn_ready;
    for (int g = DIV_STAGES - 1; g >= 0; g--) begin
      rdy[g] = !vld_r[g] || rdy[g+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[DIV_STAGES-1];
  assign dn_data  = stg_r[DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    localparam int unsigned TOP_BIT = QUO_W - 1 - QBITS * g;

    if (g == 0) begin : g_head
      always_comb begin
        src_d[g].sel  = up_data.sel;
        src_d[g].span = up_data.span;
        src_d[g].base = up_data.base;
        src_d[g].over = up_data.over;
        src_d[g].rem  = up_data.num;
        src_d[g].quo  = '0;
        src_vld[g]    = up_valid;
      end
    end else begin : g_body
      always_comb begin
        src_d[g]   = stg_r[g-1];
        src_vld[g] = vld_r[g-1];
      end
    end

    // Two quotient bits per stage, most significant first.
    always_comb begin
      num_t trial;
      stg_nxt[g] = src_d[g];
      for (int c = 0; c < NUM_CH; c++) begin
        for (int j = 0; j < QBITS; j++) begin
          trial = NUM_W'(stg_nxt[g].span) << (TOP_BIT - j);
          if (stg_nxt[g].rem[c] >= trial) begin
            stg_nxt[g].rem[c]                = stg_nxt[g].rem[c] - trial;
            stg_nxt[g].quo[c][TOP_BIT - j]   = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_r[g] <= src_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

endmodule

// ===== rtl/seam_feather_blend_unit.sv =====
// Seam feather blend: one pixel word per clock in, one pixel word out, while no
// stall holds the flow. Registers: classify, weight multiply, four divider stages
// of two quotient bits each, output register. Columns left of the overlap start
// S pass the base pixel, columns at or past the image width W pass the overlay
// pixel, and columns c in between get floor((base*(W-c)+over*(c-S))/(W-S)) per
// channel unless the overlay is dark, in which case the base pixel is kept. The
// image width saturates at 4096 and S is clamped to W. Configuration writes take
// effect for the next accepted word and must be made while no word is in flight.
module seam_feather_blend_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sfb_pkg::COL_W-1:0]      in_column,
  input  logic [sfb_pkg::PIX_W-1:0]      in_base_c0,
  input  logic [sfb_pkg::PIX_W-1:0]      in_base_c1,
  input  logic [sfb_pkg::PIX_W-1:0]      in_base_c2,
  input  logic [sfb_pkg::PIX_W-1:0]      in_over_c0,
  input  logic [sfb_pkg::PIX_W-1:0]      in_over_c1,
  input  logic [sfb_pkg::PIX_W-1:0]      in_over_c2,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sfb_pkg::PIX_W-1:0]      out_c0,
  output logic [sfb_pkg::PIX_W-1:0]      out_c1,
  output logic [sfb_pkg::PIX_W-1:0]      out_c2
);
  import sfb_pkg::*;

  logic [COL_W-1:0] start_r;
  logic [COL_W-1:0] width_r;
  rgb_t             in_base;
  rgb_t             in_over;
  logic             prep_ready;
  logic             prep_valid;
  prod_t            prep_data;
  logic             div_ready;
  logic             div_valid;
  div_t             div_data;
  logic             out_rdy;
  logic             out_valid_r;
  rgb_t             out_pix_nxt;
  rgb_t             out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      width_r <= MAX_COLUMNS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVERLAP_START: start_r <= cfg_wdata;
        REG_IMAGE_WIDTH:   width_r <= (cfg_wdata > MAX_COLUMNS) ? MAX_COLUMNS : cfg_wdata;
      endcase
    end
  end

  assign in_base  = {in_base_c2, in_base_c1, in_base_c0};
  assign in_over  = {in_over_c2, in_over_c1, in_over_c0};
  assign in_stall = !prep_ready;

  sfb_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (prep_ready),
    .column    (in_column),
    .base      (in_base),
    .over      (in_over),
    .ov_start  (start_r),
    .img_width (width_r),
    .dn_ready  (div_ready),
    .dn_valid  (prep_valid),
    .dn_data   (prep_data)
  );

  sfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (div_ready),
    .up_data  (prep_data),
    .dn_ready (out_rdy),
    .dn_valid (div_valid),
    .dn_data  (div_data)
  );

  assign out_rdy = !out_valid_r || !out_stall;

  always_comb begin
    unique case (div_data.sel)
      SEL_OVER:  out_pix_nxt = div_data.over;
      SEL_BLEND: out_pix_nxt = div_data.quo;
      default:   out_pix_nxt = div_data.base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_c0    = out_pix_r[0];
  assign out_c1    = out_pix_r[1];
  assign out_c2    = out_pix_r[2];

endmodule
